// ----- rtl/r10gps_pkg.sv -----
package r10gps_pkg;

  localparam int SRC_WIDTH  = 1280;
  localparam int SRC_HEIGHT = 720;
  localparam int OUT_WIDTH  = 1024;
  localparam int OUT_HEIGHT = 576;

  localparam int GAIN_W = 4;
  localparam int BYTE_W = 8;
  localparam int PIX_W  = 16;
  localparam int SLOT_W = 3;
  localparam int SCOL_W = 11;
  localparam int SROW_W = 10;
  localparam int PCOL_W = 10;
  localparam int PROW_W = 10;

  localparam logic [SLOT_W-1:0] SLOT_LOW_BITS = SLOT_W'(4);

  localparam logic [SCOL_W-1:0] SRC_COLS      = SCOL_W'(SRC_WIDTH);
  localparam logic [SROW_W-1:0] SRC_ROW_LAST  = SROW_W'(SRC_HEIGHT - 1);
  localparam logic [PCOL_W-1:0] OUT_COL_LAST  = PCOL_W'(OUT_WIDTH - 1);
  localparam logic [PROW_W-1:0] OUT_ROW_LAST  = PROW_W'(OUT_HEIGHT - 1);
  localparam logic [SCOL_W-1:0] OUT_COLS      = SCOL_W'(OUT_WIDTH);
  localparam logic [SROW_W:0]   OUT_ROWS      = (SROW_W + 1)'(OUT_HEIGHT);

  localparam logic [SCOL_W-1:0] COL_STEP_Q = SCOL_W'(SRC_WIDTH / OUT_WIDTH);
  localparam logic [SCOL_W-1:0] COL_STEP_R = SCOL_W'(SRC_WIDTH % OUT_WIDTH);
  localparam logic [SROW_W-1:0] ROW_STEP_Q = SROW_W'(SRC_HEIGHT / OUT_HEIGHT);
  localparam logic [SROW_W:0]   ROW_STEP_R = (SROW_W + 1)'(SRC_HEIGHT % OUT_HEIGHT);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4);

  typedef struct packed {
    logic              hit;
    logic              border;
    logic              line_end;
    logic              frame_end;
    logic [PCOL_W-1:0] column;
    logic [PROW_W-1:0] row;
  } r10gps_emit_t;

endpackage

// ----- rtl/raw10_gray_preview_scaler.sv -----
// Nearest-neighbour gray preview scaler for a packed RAW10 byte stream. One word is
// accepted per clock cycle while the input is not stalled; each word yields at most one
// RGB565 preview pixel, which moves from the input register to the result register and
// from there to the output. The coordinate counters are updated once per word, so the
// rate is set by that update and the input is stalled only while the result register
// is full and the output side stalls. A word with frame_start set restarts the frame;
// words after a completed frame produce no pixel.
// The gain should be written only while the block is idle.
module raw10_gray_preview_scaler
  import r10gps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [GAIN_W-1:0] cfg_wr_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] raw_byte_i,
  input  logic              frame_start_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PIX_W-1:0]  rgb565_pixel_o,
  output logic [PCOL_W-1:0] pixel_column_o,
  output logic [PROW_W-1:0] pixel_row_o,
  output logic              line_end_o,
  output logic              frame_end_o
);

  logic [GAIN_W-1:0] gain_q;
  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] raw_q;
  logic              fstart_q;
  logic              accept, fire;
  logic              out_valid_q, out_valid_d;
  logic [PIX_W-1:0]  rgb_q, rgb_d;
  logic [PCOL_W-1:0] col_q;
  logic [PROW_W-1:0] row_q;
  logic              le_q, fe_q;
  r10gps_emit_t      emit;

  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end

    if (fire) begin
      out_valid_d = emit.hit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  r10gps_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (fire),
    .frame_start_i (fstart_q),
    .emit_o        (emit)
  );

  r10gps_pix u_pix (
    .raw_i    (raw_q),
    .gain_i   (gain_q),
    .border_i (emit.border),
    .rgb_o    (rgb_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        gain_q <= cfg_wr_data_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q    <= raw_byte_i;
      fstart_q <= frame_start_i;
    end
    if (fire && emit.hit) begin
      rgb_q <= rgb_d;
      col_q <= emit.column;
      row_q <= emit.row;
      le_q  <= emit.line_end;
      fe_q  <= emit.frame_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rgb565_pixel_o = rgb_q;
  assign pixel_column_o = col_q;
  assign pixel_row_o    = row_q;
  assign line_end_o     = le_q;
  assign frame_end_o    = fe_q;

  a_stall_only_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register could take a word");

  a_hit_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit.hit) |=> out_valid_o)
    else $error("a selected pixel did not reach the output");

  a_coords_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pixel_column_o <= OUT_COL_LAST) && (pixel_row_o <= OUT_ROW_LAST)))
    else $error("preview coordinates out of range");

  a_frame_end_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> (line_end_o && (pixel_row_o == OUT_ROW_LAST)))
    else $error("frame end without the last line end");

endmodule

// ----- rtl/r10gps_track.sv -----
module r10gps_track
  import r10gps_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_en_i,
  input  logic         frame_start_i,
  output r10gps_emit_t emit_o
);

  logic [SLOT_W-1:0] slot_q, slot_d, cur_slot;
  logic [SCOL_W-1:0] scol_q, scol_d, cur_scol, scol_inc;
  logic [SROW_W-1:0] srow_q, srow_d, cur_srow;
  logic [PCOL_W-1:0] pcol_q, pcol_d, cur_pcol;
  logic [PROW_W-1:0] prow_q, prow_d, cur_prow;
  logic [SCOL_W-1:0] tcol_q, tcol_d, cur_tcol;
  logic [SCOL_W-1:0] crem_q, crem_d, cur_crem, csum;
  logic [SROW_W-1:0] trow_q, trow_d, cur_trow;
  logic [SROW_W-1:0] rrem_q, rrem_d, cur_rrem;
  logic [SROW_W:0]   rsum;
  logic              done_q, done_d, cur_done;
  logic              hit, last_col, last_row;

  // A frame start clears every counter before its own byte is handled.
  assign cur_slot = frame_start_i ? '0 : slot_q;
  assign cur_scol = frame_start_i ? '0 : scol_q;
  assign cur_srow = frame_start_i ? '0 : srow_q;
  assign cur_pcol = frame_start_i ? '0 : pcol_q;
  assign cur_prow = frame_start_i ? '0 : prow_q;
  assign cur_tcol = frame_start_i ? '0 : tcol_q;
  assign cur_crem = frame_start_i ? '0 : crem_q;
  assign cur_trow = frame_start_i ? '0 : trow_q;
  assign cur_rrem = frame_start_i ? '0 : rrem_q;
  assign cur_done = frame_start_i ? 1'b0 : done_q;

  assign scol_inc = cur_scol + SCOL_W'(1);
  assign csum     = cur_crem + COL_STEP_R;
  assign rsum     = {1'b0, cur_rrem} + ROW_STEP_R;
  assign last_col = cur_pcol >= OUT_COL_LAST;
  assign last_row = cur_prow >= OUT_ROW_LAST;
  assign hit      = !cur_done && (cur_slot < SLOT_LOW_BITS) &&
                    (cur_srow >= cur_trow) && (cur_scol >= cur_tcol);

  always_comb begin
    slot_d = cur_slot;
    scol_d = cur_scol;
    srow_d = cur_srow;
    pcol_d = cur_pcol;
    prow_d = cur_prow;
    tcol_d = cur_tcol;
    crem_d = cur_crem;
    trow_d = cur_trow;
    rrem_d = cur_rrem;
    done_d = cur_done;

    emit_o.hit       = hit;
    emit_o.column    = cur_pcol;
    emit_o.row       = cur_prow;
    emit_o.line_end  = last_col;
    emit_o.frame_end = last_col && last_row;
    emit_o.border    = (cur_pcol == '0) || last_col || (cur_prow == '0) || last_row;

    if (!cur_done) begin
      if (cur_slot >= SLOT_LOW_BITS) begin
        slot_d = '0;
        if (cur_scol >= SRC_COLS) begin
          scol_d = '0;
          pcol_d = '0;
          tcol_d = '0;
          crem_d = '0;
          if (cur_srow >= SRC_ROW_LAST) begin
            done_d = 1'b1;
          end else begin
            srow_d = cur_srow + SROW_W'(1);
          end
        end
      end else begin
        if (hit) begin
          if (last_col) begin
            pcol_d = '0;
            tcol_d = '0;
            crem_d = '0;
            if (last_row) begin
              done_d = 1'b1;
            end else begin
              prow_d = cur_prow + PROW_W'(1);
              if (rsum >= OUT_ROWS) begin
                rrem_d = SROW_W'(rsum - OUT_ROWS);
                trow_d = cur_trow + ROW_STEP_Q + SROW_W'(1);
              end else begin
                rrem_d = rsum[SROW_W-1:0];
                trow_d = cur_trow + ROW_STEP_Q;
              end
            end
          end else begin
            pcol_d = cur_pcol + PCOL_W'(1);
            if (csum >= OUT_COLS) begin
              crem_d = csum - OUT_COLS;
              tcol_d = cur_tcol + COL_STEP_Q + SCOL_W'(1);
            end else begin
              crem_d = csum;
              tcol_d = cur_tcol + COL_STEP_Q;
            end
          end
        end
        scol_d = scol_inc;
        slot_d = (scol_inc >= SRC_COLS) ? SLOT_LOW_BITS : cur_slot + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      scol_q <= '0;
      srow_q <= '0;
      pcol_q <= '0;
      prow_q <= '0;
      tcol_q <= '0;
      crem_q <= '0;
      trow_q <= '0;
      rrem_q <= '0;
      done_q <= 1'b0;
    end else if (step_en_i) begin
      slot_q <= slot_d;
      scol_q <= scol_d;
      srow_q <= srow_d;
      pcol_q <= pcol_d;
      prow_q <= prow_d;
      tcol_q <= tcol_d;
      crem_q <= crem_d;
      trow_q <= trow_d;
      rrem_q <= rrem_d;
      done_q <= done_d;
    end
  end

endmodule

// ----- rtl/r10gps_pix.sv -----
module r10gps_pix
  import r10gps_pkg::*;
(
  input  logic [BYTE_W-1:0] raw_i,
  input  logic [GAIN_W-1:0] gain_i,
  input  logic              border_i,
  output logic [PIX_W-1:0]  rgb_o
);

  localparam int PROD_W = BYTE_W + GAIN_W;

  logic [PROD_W-1:0] prod;
  logic [BYTE_W-1:0] gray;

  assign prod = PROD_W'(raw_i) * PROD_W'(gain_i);

  always_comb begin
    if (border_i || (|prod[PROD_W-1:BYTE_W])) begin
      gray = '1;
    end else begin
      gray = prod[BYTE_W-1:0];
    end
  end

  assign rgb_o = {gray[7:3], gray[7:2], gray[7:3]};

endmodule

// ----- tb/sv/raw10_gray_preview_scaler_test.sv -----
module raw10_gray_preview_scaler_test;
  import r10gps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_BYTES      = SRC_WIDTH + (SRC_WIDTH + 3) / 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 40;
  localparam int OPENING_LEN    = 19;

  localparam logic [BYTE_W-1:0] OPENING_BYTES [OPENING_LEN] = '{
    8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h7F, 8'h00, 8'hFF, 8'h55, 8'h12,
    8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0, 8'h0F, 8'hC3
  };
  localparam bit OPENING_STARTS [OPENING_LEN] = '{
    0, 0, 0, 0, 0, 0, 1, 0, 0, 1,
    0, 0, 0, 1, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic [BYTE_W-1:0] raw;
    logic              start;
  } sensor_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]  rgb;
    logic [PCOL_W-1:0] col;
    logic [PROW_W-1:0] row;
    logic              line_end;
    logic              frame_end;
  } preview_pixel_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_wr_en_i    = 1'b0;
  logic [GAIN_W-1:0] cfg_wr_data_i  = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] raw_byte_i     = '0;
  logic              frame_start_i  = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [PIX_W-1:0]  rgb565_pixel_o;
  logic [PCOL_W-1:0] pixel_column_o;
  logic [PROW_W-1:0] pixel_row_o;
  logic              line_end_o;
  logic              frame_end_o;

  raw10_gray_preview_scaler uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_byte_i     (raw_byte_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .rgb565_pixel_o (rgb565_pixel_o),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .line_end_o     (line_end_o),
    .frame_end_o    (frame_end_o)
  );

  sensor_word_t   sensor_words [$];
  preview_pixel_t expected_pixels [$];
  preview_pixel_t want;
  sensor_word_t   next_word;

  bit word_taken = 1'b0;
  bit calm       = 1'b0;
  int send_gap   = 0;
  int stall_left = 0;

  int unsigned words_queued    = 0;
  int unsigned words_in        = 0;
  int unsigned frames_sent     = 0;
  int unsigned pixels_checked  = 0;
  int unsigned frame_ends_seen = 0;
  int unsigned gains_used      = 1;
  int unsigned errors          = 0;

  logic [GAIN_W-1:0] gain_now = GAIN_RESET;
  logic [SLOT_W-1:0] slot_q;
  logic [SCOL_W-1:0] src_col;
  logic [SROW_W-1:0] src_row;
  logic [PCOL_W-1:0] pv_col;
  logic [PROW_W-1:0] pv_row;
  logic [SCOL_W-1:0] tgt_col;
  logic [SCOL_W-1:0] col_rem;
  logic [SROW_W-1:0] tgt_row;
  logic [SROW_W:0]   row_rem;
  bit                done;

  task automatic clear_columns();
    pv_col  = '0;
    tgt_col = '0;
    col_rem = '0;
  endtask

  task automatic restart_frame();
    slot_q  = '0;
    src_col = '0;
    src_row = '0;
    pv_row  = '0;
    tgt_row = '0;
    row_rem = '0;
    clear_columns();
    done = 1'b0;
  endtask

  // Works out the preview pixel, if any, that one accepted word gives rise to.
  task automatic scale_word(input logic [BYTE_W-1:0] raw, input logic start);
    logic [11:0]    prod;
    logic [7:0]     gray;
    logic           last_col;
    logic           last_row;
    preview_pixel_t px;
    if (start) restart_frame();
    if (done) return;
    if (slot_q >= SLOT_LOW_BITS) begin
      slot_q = '0;
      if (src_col >= SRC_COLS) begin
        src_col = '0;
        clear_columns();
        if (src_row >= SRC_ROW_LAST) done = 1'b1;
        else src_row = src_row + SROW_W'(1);
      end
      return;
    end
    if (src_row >= tgt_row && src_col >= tgt_col) begin
      last_col = pv_col >= OUT_COL_LAST;
      last_row = pv_row >= OUT_ROW_LAST;
      prod = 12'(raw) * 12'(gain_now);
      gray = (prod > 12'd255) ? 8'hFF : prod[7:0];
      if (pv_col == '0 || last_col || pv_row == '0 || last_row) gray = 8'hFF;
      px.rgb       = {gray[7:3], gray[7:2], gray[7:3]};
      px.col       = pv_col;
      px.row       = pv_row;
      px.line_end  = last_col;
      px.frame_end = last_col && last_row;
      expected_pixels.push_back(px);
      if (last_col) begin
        clear_columns();
        if (last_row) begin
          done = 1'b1;
        end else begin
          pv_row  = pv_row + PROW_W'(1);
          tgt_row = tgt_row + ROW_STEP_Q;
          row_rem = row_rem + ROW_STEP_R;
          if (row_rem >= OUT_ROWS) begin
            row_rem = row_rem - OUT_ROWS;
            tgt_row = tgt_row + SROW_W'(1);
          end
        end
      end else begin
        pv_col  = pv_col + PCOL_W'(1);
        tgt_col = tgt_col + COL_STEP_Q;
        col_rem = col_rem + COL_STEP_R;
        if (col_rem >= OUT_COLS) begin
          col_rem = col_rem - OUT_COLS;
          tgt_col = tgt_col + SCOL_W'(1);
        end
      end
    end
    src_col = src_col + SCOL_W'(1);
    slot_q  = slot_q + SLOT_W'(1);
    if (src_col >= SRC_COLS) slot_q = SLOT_LOW_BITS;
  endtask

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned wanted);
    if (errors < PRINT_CAP)
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
               wanted);
    errors++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_raw();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return BYTE_W'($urandom);
  endfunction

  task automatic queue_word(input logic [BYTE_W-1:0] raw, input logic start);
    sensor_word_t w;
    w.raw   = raw;
    w.start = start;
    sensor_words.push_back(w);
    words_queued++;
    if (start) frames_sent++;
  endtask

  task automatic queue_frame(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) queue_word(pick_raw(), i == 0);
  endtask

  // Further words of the frame that is already running.
  task automatic queue_tail(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) queue_word(pick_raw(), 1'b0);
  endtask

  // Short frames that keep restarting at random places.
  task automatic queue_noise_frame(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      queue_word(pick_raw(), i == 0 || $urandom_range(0, 15) == 0);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (words_in != words_queued || expected_pixels.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_gain(input logic [GAIN_W-1:0] g);
    drain();
    cfg_wr_en_i   = 1'b1;
    cfg_wr_data_i = g;
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
    gain_now    = g;
    gains_used++;
    @(posedge clk_i);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || word_taken) begin
        if (send_gap != 0) begin
          send_gap   = send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (sensor_words.size() != 0) begin
          next_word = sensor_words.pop_front();
          in_valid_i    <= 1'b1;
          raw_byte_i    <= next_word.raw;
          frame_start_i <= next_word.start;
          if (!calm && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (stall_left != 0) begin
        stall_left  = stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left  = $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          flag_mismatch("unexpected pixel", rgb565_pixel_o, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (rgb565_pixel_o !== want.rgb) flag_mismatch("rgb565", rgb565_pixel_o, want.rgb);
          if (pixel_column_o !== want.col) flag_mismatch("column", pixel_column_o, want.col);
          if (pixel_row_o !== want.row) flag_mismatch("row", pixel_row_o, want.row);
          if (line_end_o !== want.line_end)
            flag_mismatch("line end", line_end_o, want.line_end);
          if (frame_end_o !== want.frame_end)
            flag_mismatch("frame end", frame_end_o, want.frame_end);
          if (want.frame_end) frame_ends_seen++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        scale_word(raw_byte_i, frame_start_i);
        words_in++;
      end
      word_taken <= in_valid_i && !in_stall_o;
    end
  end

  initial begin
    int unsigned stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("FAIL raw10_gray_preview_scaler");
    $finish;
  end

  initial begin
    logic [GAIN_W-1:0] phase_gains [6];
    restart_frame();
    phase_gains = '{4'd0, 4'd15, 4'd1, 4'd9, GAIN_W'($urandom), GAIN_W'($urandom)};
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // The opening words start without frame_start, then restart mid-group and on a
    // low-bits position.
    for (int i = 0; i < OPENING_LEN; i++) queue_word(OPENING_BYTES[i], OPENING_STARTS[i]);
    repeat ($urandom_range(2, 3)) queue_noise_frame($urandom_range(1, 30));

    // One frame runs past its first source row, so that later words land inside the
    // preview where the gain shows off the border; each gain takes a stretch of it.
    queue_frame(ROW_BYTES + $urandom_range(4, 20));
    foreach (phase_gains[p]) begin
      load_gain(phase_gains[p]);
      calm = ($urandom_range(0, 3) == 0);
      queue_tail($urandom_range(12, 24));
    end

    // The last words go in at full rate, followed by a restart.
    load_gain(GAIN_W'($urandom_range(2, 14)));
    calm = 1'b1;
    queue_tail(24);
    queue_frame(12);
    drain();
    repeat (8) @(negedge clk_i);
    if (expected_pixels.size() != 0)
      flag_mismatch("pixels never produced", 0, expected_pixels.size());

    $display("Fed %0d words in %0d frames under %0d gain settings.", words_in, frames_sent,
             gains_used);
    $display("Checked %0d preview pixels, %0d of them frame ends.", pixels_checked,
             frame_ends_seen);
    if (errors == 0) begin
      $display("PASS raw10_gray_preview_scaler");
    end else begin
      $display("FAIL raw10_gray_preview_scaler");
    end
    $finish;
  end

endmodule
